[rtl/core/trsd_pkg.sv]
// Shared types, constants and length decode for the reply stream deframer.
package trsd_pkg;

    localparam int MAX_MESSAGE_DEFAULT = 532;

    localparam int POS_W   = 10;
    localparam int TOTAL_W = 17;

    // Byte positions inside a reply message
    localparam logic [POS_W-1:0] POS_FIRST   = 10'd0;
    localparam logic [POS_W-1:0] POS_CMD     = 10'd3;
    localparam logic [POS_W-1:0] POS_STATUS  = 10'd4;
    localparam logic [POS_W-1:0] POS_LEN_LO  = 10'd5;
    localparam logic [POS_W-1:0] POS_LEN_HI  = 10'd6;

    // Header plus status byte
    localparam logic [TOTAL_W-1:0] HDR_BYTES = 17'd5;

    // Command codes
    localparam logic [7:0] CMD_MOUNT   = 8'h00;
    localparam logic [7:0] CMD_OPENDIR = 8'h10;
    localparam logic [7:0] CMD_READDIR = 8'h11;
    localparam logic [7:0] CMD_READ    = 8'h21;
    localparam logic [7:0] CMD_WRITE   = 8'h22;
    localparam logic [7:0] CMD_STAT    = 8'h24;
    localparam logic [7:0] CMD_LSEEK   = 8'h25;
    localparam logic [7:0] CMD_OPEN    = 8'h29;
    localparam logic [7:0] CMD_SIZE    = 8'h30;
    localparam logic [7:0] CMD_FREE    = 8'h31;

    localparam logic [7:0] STATUS_OK = 8'h00;

    // Per-byte message markers
    typedef struct packed {
        logic first;
        logic last;
        logic err;
    } trsd_flags_t;

    // Length known at the status byte; zero when later bytes decide it
    function automatic logic [TOTAL_W-1:0] len_after_status(
        input logic [7:0] cmd,
        input logic [7:0] status
    );
        logic [TOTAL_W-1:0] len;
        len = HDR_BYTES;
        if (status == STATUS_OK)
        begin
            unique case (cmd)
                CMD_MOUNT, CMD_LSEEK, CMD_SIZE, CMD_FREE: len = HDR_BYTES + 17'd4;
                CMD_OPENDIR, CMD_OPEN:                    len = HDR_BYTES + 17'd1;
                CMD_WRITE:                                len = HDR_BYTES + 17'd2;
                CMD_STAT:                                 len = HDR_BYTES + 17'd22;
                CMD_READDIR, CMD_READ:                    len = '0;
                default:                                  len = HDR_BYTES;
            endcase
        end
        return len;
    endfunction

endpackage

[rtl/core/trsd_in_stage.sv]
// Input register stage of the reply stream deframer.
module trsd_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       can_load,
    output logic       fire,
    output logic [7:0] byte_out
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // Pass the held item on whenever the result stage can take it
    assign fire     = valid_reg && can_load;
    assign in_ready = !valid_reg || can_load;
    assign byte_out = byte_reg;

    // Fill on accept, drain on pass-on
    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the item byte
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

[rtl/core/trsd_framer.sv]
// Framing state and per-byte first/last/error decision.
module trsd_framer #(
    parameter int MAX_MESSAGE = trsd_pkg::MAX_MESSAGE_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [7:0]            byte_in,
    output trsd_pkg::trsd_flags_t flags
);

    localparam int POS_W   = trsd_pkg::POS_W;
    localparam int TOTAL_W = trsd_pkg::TOTAL_W;
    localparam logic [POS_W:0]     MaxPos   = (POS_W+1)'(MAX_MESSAGE);
    localparam logic [TOTAL_W-1:0] MaxTotal = TOTAL_W'(MAX_MESSAGE);

    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [7:0]         cmd_reg;
    logic [7:0]         cmd_next;
    logic [7:0]         len_lo_reg;
    logic [7:0]         len_lo_next;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;

    logic [TOTAL_W-1:0] total_upd;
    logic [POS_W:0]     pos_inc;

    // Decode length from the current byte and mark the message edges
    always_comb
    begin
        cmd_next    = cmd_reg;
        len_lo_next = len_lo_reg;
        total_upd   = total_reg;
        pos_inc     = {1'b0, pos_reg} + (POS_W+1)'(1);
        flags.first = (pos_reg == trsd_pkg::POS_FIRST);
        flags.last  = 1'b0;
        flags.err   = 1'b0;

        if (pos_reg == trsd_pkg::POS_CMD)
        begin
            cmd_next = byte_in;
        end
        else if (pos_reg == trsd_pkg::POS_STATUS)
        begin
            total_upd = trsd_pkg::len_after_status(cmd_reg, byte_in);
        end
        else if (pos_reg > trsd_pkg::POS_STATUS && total_reg == '0)
        begin
            if (cmd_reg == trsd_pkg::CMD_READDIR)
            begin
                if (byte_in == 8'h00)
                begin
                    total_upd = TOTAL_W'(pos_inc);
                end
            end
            else if (cmd_reg == trsd_pkg::CMD_READ)
            begin
                if (pos_reg == trsd_pkg::POS_LEN_LO)
                begin
                    len_lo_next = byte_in;
                end
                else if (pos_reg == trsd_pkg::POS_LEN_HI)
                begin
                    total_upd = trsd_pkg::HDR_BYTES + TOTAL_W'(2)
                              + TOTAL_W'({byte_in, len_lo_reg});
                end
            end
        end

        if (total_upd != '0)
        begin
            if (total_upd > MaxTotal)
            begin
                flags.last = 1'b1;
                flags.err  = 1'b1;
            end
            else if (TOTAL_W'(pos_inc) == total_upd)
            begin
                flags.last = 1'b1;
            end
        end
        else if (pos_inc >= MaxPos)
        begin
            flags.last = 1'b1;
            flags.err  = 1'b1;
        end

        // Restart framing after the last byte
        if (flags.last)
        begin
            pos_next   = '0;
            total_next = '0;
        end
        else
        begin
            pos_next   = pos_inc[POS_W-1:0];
            total_next = total_upd;
        end
    end

    // Advance state once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            cmd_reg    <= '0;
            len_lo_reg <= '0;
            total_reg  <= '0;
        end
        else if (fire)
        begin
            pos_reg    <= pos_next;
            cmd_reg    <= cmd_next;
            len_lo_reg <= len_lo_next;
            total_reg  <= total_next;
        end
    end

`ifndef SYNTHESIS
    a_err_ends_message: assert property (@(posedge clk) disable iff (!rst_n)
        flags.err |-> flags.last)
        else $error("frame error without end of message");

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && flags.last |=> pos_reg == '0 && total_reg == '0)
        else $error("framing did not restart after last byte");

    a_pos_advances: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !flags.last |=> pos_reg == $past(pos_reg) + POS_W'(1))
        else $error("byte position did not advance");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, pos_reg} < MaxPos)
        else $error("byte position beyond maximum message size");
`endif

endmodule

[rtl/core/trsd_out_stage.sv]
// Result register stage of the reply stream deframer.
module trsd_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [7:0]            byte_in,
    input  trsd_pkg::trsd_flags_t flags_in,
    output logic                  can_load,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            data_byte,
    output logic                  first_of_message,
    output logic                  last_of_message,
    output logic                  frame_error
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [7:0]            byte_reg;
    trsd_pkg::trsd_flags_t flags_reg;

    // Room when empty or when the held result leaves this cycle
    assign can_load         = !valid_reg || out_ready;
    assign out_valid        = valid_reg;
    assign data_byte        = byte_reg;
    assign first_of_message = flags_reg.first;
    assign last_of_message  = flags_reg.last;
    assign frame_error      = flags_reg.err;

    // Fill on load, drain on take
    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            byte_reg  <= byte_in;
            flags_reg <= flags_in;
        end
    end

endmodule

[rtl/core/tnfs_reply_stream_deframer.sv]
// Reply stream deframer: marks message boundaries in a received reply byte stream.
//
// Input channel: rx_byte with in_valid/in_ready, one received byte per item.
// Output channel: data_byte with first_of_message, last_of_message and
// frame_error, under out_valid/out_ready; exactly one result item per input item,
// in order, with the byte unchanged.
// Each accepted byte passes one input register, then the framing decision, then
// the result register, which offers it under out_valid.
// Throughput is one item per cycle while out_ready stays high; the framing state
// updates once per byte, so consecutive bytes never wait on each other.
// A message that would exceed MAX_MESSAGE bytes ends early with frame_error and
// last_of_message set on the cutting byte; framing restarts at the next byte.
// Reset clears both stage valid flags and the framing state, so the first byte
// after reset starts a new message.
// When the receiver stalls, the result register holds and the input register
// keeps one more item; in_ready drops only while both are full and out_ready low.
module tnfs_reply_stream_deframer #(
    parameter int MAX_MESSAGE = trsd_pkg::MAX_MESSAGE_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic       first_of_message,
    output logic       last_of_message,
    output logic       frame_error
);

    logic                  can_load;
    logic                  fire;
    logic [7:0]            stage_byte;
    trsd_pkg::trsd_flags_t flags;

    trsd_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .can_load (can_load),
        .fire     (fire),
        .byte_out (stage_byte)
    );

    trsd_framer #(
        .MAX_MESSAGE (MAX_MESSAGE)
    ) u_framer (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .byte_in (stage_byte),
        .flags   (flags)
    );

    trsd_out_stage u_out_stage (
        .clk              (clk),
        .rst_n            (rst_n),
        .fire             (fire),
        .byte_in          (stage_byte),
        .flags_in         (flags),
        .can_load         (can_load),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .data_byte        (data_byte),
        .first_of_message (first_of_message),
        .last_of_message  (last_of_message),
        .frame_error      (frame_error)
    );

endmodule

[test/tnfs_reply_stream_deframer_tb.sv]
// Self-checking testbench for the reply stream deframer: message boundaries and frame errors.
`timescale 1ns / 1ps

module tnfs_reply_stream_deframer_tb;

    localparam int POS_W      = trsd_pkg::POS_W;
    localparam int TOTAL_W    = trsd_pkg::TOTAL_W;
    localparam int MAX_MSG    = trsd_pkg::MAX_MESSAGE_DEFAULT;
    localparam int HDR_LEN    = 5;
    localparam int READ_EXTRA = 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 120;
    localparam logic [7:0] CMD_UNKNOWN = 8'hFF;

    // One framed byte as the block should deliver it
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       err;
    } framed_byte_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] data_byte;
    logic       first_of_message;
    logic       last_of_message;
    logic       frame_error;

    // Framing state of the predictor
    logic [POS_W-1:0]   msg_pos = '0;
    logic [7:0]         msg_cmd = '0;
    logic [7:0]         count_lo = '0;
    logic [TOTAL_W-1:0] msg_len = '0;

    framed_byte_t pending_marks[$];
    int  mismatches = 0;
    int  items_sent = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  gaps_on = 1'b1;

    tnfs_reply_stream_deframer #(
        .MAX_MESSAGE(MAX_MSG)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .data_byte(data_byte),
        .first_of_message(first_of_message),
        .last_of_message(last_of_message),
        .frame_error(frame_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Message length known once the status byte is in; zero when later bytes decide it
    function automatic logic [TOTAL_W-1:0] status_length(input logic [7:0] cmd,
                                                         input logic [7:0] status);
        if (status != trsd_pkg::STATUS_OK)
            return TOTAL_W'(HDR_LEN);
        case (cmd)
            trsd_pkg::CMD_MOUNT, trsd_pkg::CMD_LSEEK,
            trsd_pkg::CMD_SIZE, trsd_pkg::CMD_FREE:
                return TOTAL_W'(HDR_LEN + 4);
            trsd_pkg::CMD_OPENDIR, trsd_pkg::CMD_OPEN:
                return TOTAL_W'(HDR_LEN + 1);
            trsd_pkg::CMD_WRITE:
                return TOTAL_W'(HDR_LEN + 2);
            trsd_pkg::CMD_STAT:
                return TOTAL_W'(HDR_LEN + 22);
            trsd_pkg::CMD_READDIR, trsd_pkg::CMD_READ:
                return '0;
            default:
                return TOTAL_W'(HDR_LEN);
        endcase
    endfunction

    // Advance the framing state by one byte and return its markers
    function automatic framed_byte_t frame_byte(input logic [7:0] b);
        framed_byte_t r;
        r.data  = b;
        r.first = (msg_pos == trsd_pkg::POS_FIRST);
        r.last  = 1'b0;
        r.err   = 1'b0;

        if (msg_pos == trsd_pkg::POS_CMD)
            msg_cmd = b;
        else if (msg_pos == trsd_pkg::POS_STATUS)
            msg_len = status_length(msg_cmd, b);
        else if (msg_pos > trsd_pkg::POS_STATUS && msg_len == '0)
        begin
            if (msg_cmd == trsd_pkg::CMD_READDIR)
            begin
                if (b == 8'h00)
                    msg_len = {7'd0, msg_pos} + 17'd1;
            end
            else if (msg_cmd == trsd_pkg::CMD_READ)
            begin
                if (msg_pos == trsd_pkg::POS_LEN_LO)
                    count_lo = b;
                else if (msg_pos == trsd_pkg::POS_LEN_HI)
                    msg_len = TOTAL_W'(HDR_LEN + READ_EXTRA) + {1'b0, b, count_lo};
            end
        end

        // Decide where the message ends
        if (msg_len != '0)
        begin
            if (msg_len > TOTAL_W'(MAX_MSG))
            begin
                r.last = 1'b1;
                r.err  = 1'b1;
            end
            else if ({7'd0, msg_pos} + 17'd1 == msg_len)
                r.last = 1'b1;
        end
        else if (int'(msg_pos) + 1 >= MAX_MSG)
        begin
            r.last = 1'b1;
            r.err  = 1'b1;
        end

        if (r.last)
        begin
            msg_pos = '0;
            msg_len = '0;
        end
        else
            msg_pos = msg_pos + 1'b1;
        return r;
    endfunction

    // Offer one byte, with random gaps, and record its markers once accepted
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while (gaps_on && $urandom_range(0, 99) < 24)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        pending_marks.push_back(frame_byte(b));
        items_sent++;
    endtask

    task automatic send_fill(input int n, input bit nonzero);
        for (int i = 0; i < n; i++)
            send_byte(nonzero ? 8'($urandom_range(1, 255)) : 8'($urandom));
    endtask

    task automatic send_header(input logic [7:0] cmd, input logic [7:0] status);
        send_fill(3, 1'b0);
        send_byte(cmd);
        send_byte(status);
    endtask

    // Body of a status-OK reply: name for readdir, count and data for read, fixed payload otherwise
    task automatic send_body(input logic [7:0] cmd, input int name_len, input int count);
        if (cmd == trsd_pkg::CMD_READDIR)
        begin
            send_fill(name_len, 1'b1);
            send_byte(8'h00);
        end
        else if (cmd == trsd_pkg::CMD_READ)
        begin
            send_byte(8'(count));
            send_byte(8'(count >> 8));
            if (count + HDR_LEN + READ_EXTRA <= MAX_MSG)
                send_fill(count, 1'b0);
        end
        else
            send_fill(int'(status_length(cmd, trsd_pkg::STATUS_OK)) - HDR_LEN, 1'b0);
    endtask

    function automatic logic [7:0] cmd_by_index(input int i);
        case (i)
            0:       return trsd_pkg::CMD_MOUNT;
            1:       return trsd_pkg::CMD_OPENDIR;
            2:       return trsd_pkg::CMD_READDIR;
            3:       return trsd_pkg::CMD_READ;
            4:       return trsd_pkg::CMD_WRITE;
            5:       return trsd_pkg::CMD_STAT;
            6:       return trsd_pkg::CMD_LSEEK;
            7:       return trsd_pkg::CMD_OPEN;
            8:       return trsd_pkg::CMD_SIZE;
            9:       return trsd_pkg::CMD_FREE;
            default: return CMD_UNKNOWN;
        endcase
    endfunction

    // Feed filler until the block is back at a message start
    task automatic realign;
        while (msg_pos != trsd_pkg::POS_FIRST)
            send_byte(msg_pos > trsd_pkg::POS_STATUS ? 8'h00 : 8'($urandom));
    endtask

    task automatic test_status_errors;
        send_header(trsd_pkg::CMD_MOUNT, 8'hFF);
        send_header(trsd_pkg::CMD_READDIR, 8'h01);
        send_header(trsd_pkg::CMD_READ, 8'h80);
        send_header(trsd_pkg::CMD_STAT, 8'hFF);
    endtask

    task automatic test_every_command;
        for (int i = 0; i <= 10; i++)
        begin
            send_header(cmd_by_index(i), trsd_pkg::STATUS_OK);
            send_body(cmd_by_index(i), 2, 3);
        end
        // unknown command close to a known one
        send_header(8'h01, trsd_pkg::STATUS_OK);
        send_header(trsd_pkg::CMD_READDIR, trsd_pkg::STATUS_OK);
        send_body(trsd_pkg::CMD_READDIR, 0, 0);
    endtask

    task automatic test_read_lengths;
        send_header(trsd_pkg::CMD_READ, trsd_pkg::STATUS_OK);
        send_body(trsd_pkg::CMD_READ, 0, 0);
        // count one past the limit, then the largest count
        send_header(trsd_pkg::CMD_READ, trsd_pkg::STATUS_OK);
        send_body(trsd_pkg::CMD_READ, 0, MAX_MSG - HDR_LEN - READ_EXTRA + 1);
        send_header(trsd_pkg::CMD_READ, trsd_pkg::STATUS_OK);
        send_body(trsd_pkg::CMD_READ, 0, 16'hFFFF);
    endtask

    task automatic test_readdir_limits;
        // NUL at the last allowed position ends the message cleanly
        send_header(trsd_pkg::CMD_READDIR, trsd_pkg::STATUS_OK);
        send_body(trsd_pkg::CMD_READDIR, MAX_MSG - HDR_LEN - 1, 0);
        // no NUL in reach: cut at the limit
        send_header(trsd_pkg::CMD_READDIR, trsd_pkg::STATUS_OK);
        send_fill(MAX_MSG - HDR_LEN, 1'b1);
        send_header(trsd_pkg::CMD_OPEN, trsd_pkg::STATUS_OK);
        send_body(trsd_pkg::CMD_OPEN, 0, 0);
    endtask

    // One message, mostly well formed, sometimes noise or cut short
    task automatic send_random_message;
        int pick;
        int name_len;
        int count;
        logic [7:0] cmd;
        logic [7:0] status;
        realign();
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            send_fill($urandom_range(1, 12), 1'b0);
            return;
        end
        cmd = ($urandom_range(0, 9) == 0) ? 8'($urandom) : cmd_by_index($urandom_range(0, 10));
        status = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255))
                                             : trsd_pkg::STATUS_OK;
        send_header(cmd, status);
        if (status != trsd_pkg::STATUS_OK)
            return;
        if (pick < 13)
        begin
            send_fill($urandom_range(0, 3), 1'b0);
            return;
        end
        name_len = $urandom_range(0, 24);
        case ($urandom_range(0, 19))
            0, 1:    count = $urandom_range(0, 16'hFFFF);
            2:       count = $urandom_range(MAX_MSG - HDR_LEN - READ_EXTRA - 4,
                                            MAX_MSG - HDR_LEN - READ_EXTRA + 4);
            default: count = $urandom_range(0, 40);
        endcase
        send_body(cmd, name_len, count);
    endtask

    task automatic test_back_pressure;
        // hold the receiver while the sender offers back to back
        gaps_on = 1'b0;
        hold_left = 200;
        for (int i = 0; i < 4; i++)
            send_random_message();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_stream;
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS / 3)
            send_random_message();
        gaps_on = 1'b0;
        while (items_sent - start < 2 * RANDOM_ITEMS / 3)
            send_random_message();
        gaps_on = 1'b1;
        while (items_sent - start < RANDOM_ITEMS)
            send_random_message();
    endtask

    // Drive out_ready: long hold when requested, random stalls otherwise
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= !(gaps_on && $urandom_range(0, 99) < 24);
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare each delivered byte with the oldest prediction
    always @(posedge clk)
    begin
        framed_byte_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_marks.size() == 0)
            begin
                $display("%0t: unexpected item, data_byte actual %0h", $time, data_byte);
                mismatches++;
            end
            else
            begin
                want = pending_marks.pop_front();
                check_field("data_byte", want.data, data_byte);
                check_field("first_of_message", 8'(want.first), 8'(first_of_message));
                check_field("last_of_message", 8'(want.last), 8'(last_of_message));
                check_field("frame_error", 8'(want.err), 8'(frame_error));
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tnfs_reply_stream_deframer regression: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_status_errors();
        test_every_command();
        test_read_lengths();
        test_readdir_limits();
        test_back_pressure();
        test_random_stream();

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_marks.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("tnfs_reply_stream_deframer regression: pass");
        else
            $display("tnfs_reply_stream_deframer regression: fail");
        $finish;
    end

endmodule
